// ===== hw/rtl/qcse_pkg.sv =====
package qcse_pkg;

	localparam int CNT_VAL_W = 32;
	localparam int PERIOD_W = 16;
	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'b0010;

	localparam int MUL_W = 10;
	localparam logic [MUL_W-1:0] MS_PER_S = 10'd1000;
	// |delta| * 1000 <= 2^31 * 1000 < 2^41
	localparam int PROD_W = 41;
	localparam int STEP_W = $clog2(PROD_W);

	localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] RATE_MIN = 32'h8000_0000;

	typedef enum logic {
		KIND_START  = 1'b0,
		KIND_UPDATE = 1'b1
	} kind_t;

	typedef struct packed {
		logic                kind;
		logic [1:0]          channel;
		logic [CNT_VAL_W-1:0] counter_value;
		logic [PERIOD_W-1:0] period_ms;
	} qcse_in_t;

	typedef struct packed {
		logic signed [31:0]   delta_count;
		logic signed [31:0]   speed;
		logic [CNT_VAL_W-1:0] last_count;
		logic                 skipped;
	} qcse_out_t;

	typedef struct packed {
		logic capture;
		logic load_delta;
		logic load_mul;
		logic div_step;
		logic commit;
	} qcse_cmd_t;

	typedef struct packed {
		logic need_div;
	} qcse_sts_t;

endpackage

// ===== hw/rtl/quadrature_count_speed_estimator.sv =====
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_item   (qcse_in_t)
// out       output     out_valid / out_ready out_item  (qcse_out_t)
// cfg       input      cfg_we                cfg_wdata (wide_channels)
//
// An update request with nonzero period passes the multiply step and the
// bit-serial divider (one quotient bit per cycle, 41 in all) before the next accept.
// Start, skipped and out-of-range requests bypass the multiply and divide.
// Reset clears all channel state and sets wide_channels to channel 1 only.
// A result waits in the output register; a stalled output holds back only
// the following request's final commit.
module quadrature_count_speed_estimator #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  qcse_pkg::qcse_in_t         in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output qcse_pkg::qcse_out_t        out_item,
	input  logic                       cfg_we,
	input  logic [qcse_pkg::CFG_W-1:0] cfg_wdata
);
	import qcse_pkg::*;

	qcse_cmd_t cmd;
	qcse_sts_t sts;

	qcse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	qcse_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

endmodule

// ===== hw/rtl/qcse_ctrl.sv =====
module qcse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  qcse_pkg::qcse_sts_t sts,
	output qcse_pkg::qcse_cmd_t cmd
);
	import qcse_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DELTA = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic out_valid_q;
	logic last_step;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign last_step = (step_q == STEP_W'(PROD_W - 1));

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: begin
				cmd.load_delta = 1'b1;
				state_d = sts.need_div ? ST_MUL : ST_FIN;
			end
			ST_MUL: begin
				cmd.load_mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_mul) step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + 1'b1;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> step_q < STEP_W'(PROD_W))
		else $error("divider step count overran");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DELTA)
		else $error("accepted request not started");
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ready)
		else $error("commit would overwrite pending result");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && state_q == ST_IDLE)
		else $error("commit did not raise output valid");

endmodule

// ===== hw/rtl/qcse_dp.sv =====
module qcse_dp #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qcse_pkg::CFG_W-1:0]    cfg_wdata,
	input  qcse_pkg::qcse_in_t            in_item,
	input  qcse_pkg::qcse_cmd_t           cmd,
	output qcse_pkg::qcse_sts_t           sts,
	output qcse_pkg::qcse_out_t           out_item
);
	import qcse_pkg::*;

	logic [CFG_W-1:0] wide_q;
	qcse_in_t in_q;
	logic [31:0] prev_q [NUM_CHANNELS];
	logic [31:0] chg_q  [NUM_CHANNELS];
	logic [31:0] rate_q [NUM_CHANNELS];
	logic [31:0] delta_q;
	logic [PROD_W-1:0] dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	qcse_out_t out_q;

	logic [31:0] prev_sel, chg_sel, rate_sel;
	logic ch_ok, upd, strt;
	logic [31:0] diff, delta_d, abs_d;
	logic [PROD_W-1:0] prod;
	logic [PERIOD_W:0] rem_sh;
	logic ge;
	logic big;
	logic [31:0] rate_d, new_prev, new_chg, new_rate;
	qcse_out_t out_d;

	always_comb begin
		prev_sel = '0;
		chg_sel = '0;
		rate_sel = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (32'(in_q.channel) == i) begin
				prev_sel = prev_q[i];
				chg_sel = chg_q[i];
				rate_sel = rate_q[i];
			end
		end
	end

	assign ch_ok = (32'(in_q.channel) < NUM_CHANNELS);
	assign upd = ch_ok && (in_q.kind == KIND_UPDATE) && (in_q.period_ms != '0);
	assign strt = ch_ok && (in_q.kind == KIND_START);
	assign sts.need_div = upd;

	// narrow counters wrap modulo 2^16 and sign-extend
	assign diff = in_q.counter_value - prev_sel;
	assign delta_d = wide_q[in_q.channel] ? diff : {{16{diff[15]}}, diff[15:0]};

	assign abs_d = delta_q[31] ? (~delta_q + 32'd1) : delta_q;
	assign prod = PROD_W'(abs_d) * PROD_W'(MS_PER_S);

	// restoring division, one quotient bit per step
	assign rem_sh = {rem_q, dvd_q[PROD_W-1]};
	assign ge = (rem_sh >= {1'b0, in_q.period_ms});

	// quotient magnitude at or above 2^31 saturates either way
	assign big = |dvd_q[PROD_W-1:31];
	always_comb begin
		if (delta_q[31]) rate_d = big ? RATE_MIN : (~dvd_q[31:0] + 32'd1);
		else rate_d = big ? RATE_MAX : dvd_q[31:0];
	end

	always_comb begin
		new_prev = (upd || strt) ? in_q.counter_value : prev_sel;
		new_chg = upd ? delta_q : (strt ? 32'd0 : chg_sel);
		new_rate = upd ? rate_d : (strt ? 32'd0 : rate_sel);
		out_d = '0;
		if (ch_ok) begin
			out_d.delta_count = new_chg;
			out_d.speed = new_rate;
			out_d.last_count = new_prev;
			out_d.skipped = (in_q.kind == KIND_UPDATE) && (in_q.period_ms == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= CFG_RESET;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				prev_q[i] <= '0;
				chg_q[i] <= '0;
				rate_q[i] <= '0;
			end
		end else begin
			if (cfg_we) wide_q <= cfg_wdata;
			if (cmd.commit) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (32'(in_q.channel) == i) begin
						prev_q[i] <= new_prev;
						chg_q[i] <= new_chg;
						rate_q[i] <= new_rate;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_item;
		if (cmd.load_delta) delta_q <= delta_d;
		if (cmd.load_mul) begin
			dvd_q <= prod;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? PERIOD_W'(rem_sh - {1'b0, in_q.period_ms}) : rem_sh[PERIOD_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], ge};
		end
		if (cmd.commit) out_q <= out_d;
	end

	assign out_item = out_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> rem_q < in_q.period_ms)
		else $error("divider remainder not below period");

endmodule

// ===== sim/tb_quadrature_count_speed_estimator.sv =====
`timescale 1ns / 100ps

module tb_quadrature_count_speed_estimator;
	import qcse_pkg::*;

	localparam int CHANNELS = 4;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_PER_PHASE = 140;
	localparam int unsigned HOLD_AT = 200;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned SHOWN_ERRORS = 10;
	localparam longint SPEED_HI = 64'sd2147483647;
	localparam longint SPEED_LO = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	qcse_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	qcse_out_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = CFG_RESET;

	// predictor copy of the block state
	logic [CFG_W-1:0] wide_mask = CFG_RESET;
	logic [31:0] base_count [CHANNELS];
	logic [31:0] stored_delta [CHANNELS];
	logic [31:0] stored_speed [CHANNELS];

	// stimulus side
	logic [31:0] gen_last [CHANNELS];
	qcse_in_t sample_queue [$];
	qcse_out_t expected_reports [$];

	int unsigned accepted_count = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	int unsigned ready_mode = 0;
	int unsigned mode_left = 0;
	qcse_out_t expected_now;

	quadrature_count_speed_estimator #(
		.NUM_CHANNELS(CHANNELS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic qcse_out_t predict_channel_report(qcse_in_t req);
		qcse_out_t res;
		logic [31:0] diff;
		longint scaled;
		int unsigned ch;
		res = '0;
		ch = 32'(req.channel);
		if (req.kind == KIND_START) begin
			base_count[ch] = req.counter_value;
			stored_delta[ch] = '0;
			stored_speed[ch] = '0;
		end else if (req.period_ms == '0) begin
			res.skipped = 1'b1;
		end else begin
			diff = req.counter_value - base_count[ch];
			if (!wide_mask[ch])
				diff = {{16{diff[15]}}, diff[15:0]};
			scaled = longint'($signed(diff)) * 1000;
			scaled = scaled / longint'({48'd0, req.period_ms});
			stored_delta[ch] = diff;
			base_count[ch] = req.counter_value;
			if (scaled > SPEED_HI)
				stored_speed[ch] = RATE_MAX;
			else if (scaled < SPEED_LO)
				stored_speed[ch] = RATE_MIN;
			else
				stored_speed[ch] = scaled[31:0];
		end
		res.delta_count = stored_delta[ch];
		res.speed = stored_speed[ch];
		res.last_count = base_count[ch];
		return res;
	endfunction

	function automatic qcse_in_t make_req(kind_t kind, int unsigned ch, logic [31:0] value,
			logic [15:0] period);
		qcse_in_t req;
		req.kind = kind;
		req.channel = ch[1:0];
		req.counter_value = value;
		req.period_ms = period;
		return req;
	endfunction

	// mostly plausible encoder motion, some full-range jumps and wraps
	function automatic qcse_in_t random_sample();
		qcse_in_t req;
		int unsigned ch;
		int step;
		ch = $urandom_range(0, CHANNELS - 1);
		req.channel = ch[1:0];
		req.kind = ($urandom_range(0, 9) == 0) ? KIND_START : KIND_UPDATE;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				step = $urandom_range(0, 2000);
				req.counter_value = gen_last[ch] + step - 1000;
			end
			5, 6: begin
				step = $urandom_range(0, 80000);
				req.counter_value = gen_last[ch] + step - 40000;
			end
			default: req.counter_value = $urandom;
		endcase
		gen_last[ch] = req.counter_value;
		case ($urandom_range(0, 9))
			0: req.period_ms = '0;
			1: req.period_ms = 16'd1;
			2: req.period_ms = 16'hFFFF;
			3, 4: req.period_ms = 16'($urandom_range(0, 65535));
			default: req.period_ms = 16'($urandom_range(1, 1000));
		endcase
		return req;
	endfunction

	task automatic wait_drained();
		while (sample_queue.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_wide_mask(logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		wide_mask = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				in_item <= sample_queue.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: stall modes change now and then, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (!hold_done && accepted_count >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left = mode_left - 1;
				end
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// monitor: predict on request accept, check on result accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_reports.push_back(predict_channel_report(in_item));
				accepted_count++;
			end
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					error_count++;
					if (error_count <= SHOWN_ERRORS)
						$display("unexpected result: delta %0d speed %0d last %h skip %b",
							out_item.delta_count, out_item.speed, out_item.last_count,
							out_item.skipped);
				end else begin
					expected_now = expected_reports.pop_front();
					if (out_item.delta_count !== expected_now.delta_count ||
							out_item.speed !== expected_now.speed ||
							out_item.last_count !== expected_now.last_count ||
							out_item.skipped !== expected_now.skipped) begin
						error_count++;
						if (error_count <= SHOWN_ERRORS) begin
							$display("mismatch: exp delta %0d speed %0d last %h skip %b",
								expected_now.delta_count, expected_now.speed,
								expected_now.last_count, expected_now.skipped);
							$display("          got delta %0d speed %0d last %h skip %b",
								out_item.delta_count, out_item.speed,
								out_item.last_count, out_item.skipped);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_masks [5];
		phase_masks = '{4'hF, 4'h0, 4'hA, 4'h5, 4'h0};
		phase_masks[4] = CFG_W'($urandom_range(0, 15));
		for (int c = 0; c < CHANNELS; c++) begin
			base_count[c] = '0;
			stored_delta[c] = '0;
			stored_speed[c] = '0;
			gen_last[c] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset mask (channel 1 wide)
		sample_queue.push_back(make_req(KIND_UPDATE, 3, 32'd5, 16'd1));
		sample_queue.push_back(make_req(KIND_START, 0, 32'h0000_0000, 16'd0));
		sample_queue.push_back(make_req(KIND_UPDATE, 0, 32'h0000_0000, 16'd0));
		sample_queue.push_back(make_req(KIND_UPDATE, 0, 32'h0000_7FFF, 16'd1));
		sample_queue.push_back(make_req(KIND_UPDATE, 0, 32'hFFFF_FFFF, 16'd1));
		sample_queue.push_back(make_req(KIND_UPDATE, 0, 32'h1234_0005, 16'd3));
		sample_queue.push_back(make_req(KIND_START, 1, 32'h0000_0000, 16'hFFFF));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'h7FFF_FFFF, 16'd1));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'hFFFF_FFFF, 16'd1));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'h7FFF_FFFF, 16'hFFFF));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'h7FFF_FFF8, 16'd3));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'h7FFF_FFFF, 16'd3));
		sample_queue.push_back(make_req(KIND_START, 1, 32'hFFFF_FFF0, 16'd1));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'h0000_0010, 16'd7));
		sample_queue.push_back(make_req(KIND_UPDATE, 1, 32'h0000_0020, 16'd0));
		sample_queue.push_back(make_req(KIND_START, 2, 32'hFFFF_FFFF, 16'hFFFF));
		sample_queue.push_back(make_req(KIND_UPDATE, 2, 32'h0000_0000, 16'hFFFF));
		sample_queue.push_back(make_req(KIND_UPDATE, 2, 32'hAAAA_5555, 16'h8000));
		sample_queue.push_back(make_req(KIND_UPDATE, 3, 32'h0000_0000, 16'd0));
		sample_queue.push_back(make_req(KIND_START, 3, 32'h5555_AAAA, 16'd0));
		sample_queue.push_back(make_req(KIND_UPDATE, 3, 32'h5555_AAAA, 16'd1));
		sample_queue.push_back(make_req(KIND_UPDATE, 3, 32'hDEAD_2AAA, 16'd250));
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			write_wide_mask(phase_masks[ph]);
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				sample_queue.push_back(random_sample());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
